@@ src/polynomial_term_parser_core_defines.svh @@
// ----------------------------------------------------------------------------
// Polynomial term parser assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_TERM_PARSER_CORE_DEFINES_SVH
`define POLYNOMIAL_TERM_PARSER_CORE_DEFINES_SVH

// check cons in the same cycle as ante
`define PTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define PTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ptp_pkg.sv @@
// ----------------------------------------------------------------------------
// Polynomial term parser package
// Field widths, character codes, item and result types.
// ----------------------------------------------------------------------------
package ptp_pkg;

   localparam int COEFF_BITS      = 32;
   localparam int EXPO_BITS       = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_XU    = 8'h58;
   localparam logic [7:0] CH_XL    = 8'h78;

   localparam logic [1:0] KIND_TERM    = 2'd0;
   localparam logic [1:0] KIND_INVALID = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [1:0]                   result_kind;
      logic signed [COEFF_BITS-1:0] term_coeff;
      logic [EXPO_BITS-1:0]         term_expo;
      logic                         text_done;
   } rsp_type;

   typedef enum logic [1:0] {
      CLS_SIGN,
      CLS_DIGIT,
      CLS_X,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic       neg;
      logic [3:0] digit;
      logic       last;
   } cmd_type;

   typedef enum logic {
      PS_COEFF,
      PS_EXPO
   } ps_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic pend_valid;
      logic busy;
   } bk_stat_type;

endpackage

@@ src/polynomial_term_parser_core.sv @@
// ----------------------------------------------------------------------------
// Polynomial term parser core
// Splits polynomial text into signed coefficient and exponent terms.
//
//   channel  dir  ports                        payload
//   req      in   req_valid, req_stall         req_type: one character
//   rsp      out  rsp_valid, rsp_stall         rsp_type: one term or status
//
// One character per cycle, set by the parser step in the back end, while the
// output is not stalled and no second result waits. A last character that is
// invalid or a term-closing sign gives two results; the second is held pending.
// Synchronous reset clears the queue, the parser state and the output stage.
// The command queue lets the input keep flowing while the output is stalled.
// ----------------------------------------------------------------------------
`include "polynomial_term_parser_core_defines.svh"

module polynomial_term_parser_core
   import ptp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        push, pop;
   cmd_type     push_cmd, head_cmd;
   q_stat_type  q_stat;
   bk_stat_type bk_stat;

   ptp_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   ptp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   ptp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .bk_stat   (bk_stat)
   );

   `PTP_ASSERT_NEXT(a_push_fills, clock, reset, req_valid && !req_stall, !q_stat.empty, "queue empty after accepted item")
   `PTP_ASSERT_NOW(a_pend_out, clock, reset, bk_stat.pend_valid, rsp_valid, "pending result without valid output")
   `PTP_ASSERT_NOW(a_inv_done, clock, reset, rsp_valid && rsp_data.result_kind == KIND_INVALID, !rsp_data.text_done, "invalid item marked as end of text")

endmodule

@@ src/ptp_front.sv @@
// ----------------------------------------------------------------------------
// Polynomial term parser front end
// Accepts characters and classifies them into queue commands.
// ----------------------------------------------------------------------------
module ptp_front
   import ptp_pkg::*;
(
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   input  q_stat_type q_stat,
   output logic       push,
   output cmd_type    push_cmd
);

   logic [7:0] digit_off;

   assign digit_off = req_data.text_char - CH_ZERO;
   assign req_stall = q_stat.full;
   assign push      = req_valid & ~q_stat.full;

   always_comb begin
      push_cmd.neg   = (req_data.text_char == CH_MINUS);
      push_cmd.digit = digit_off[3:0];
      push_cmd.last  = req_data.end_of_text;
      if (req_data.text_char inside {CH_PLUS, CH_MINUS}) begin
         push_cmd.cls = CLS_SIGN;
      end else if (req_data.text_char inside {[CH_ZERO:CH_NINE]}) begin
         push_cmd.cls = CLS_DIGIT;
      end else if (req_data.text_char inside {CH_XL, CH_XU}) begin
         push_cmd.cls = CLS_X;
      end else begin
         push_cmd.cls = CLS_OTHER;
      end
   end

endmodule

@@ src/ptp_queue.sv @@
// ----------------------------------------------------------------------------
// Polynomial term parser command queue
// Short first-in first-out store between front end and back end.
// ----------------------------------------------------------------------------
module ptp_queue
   import ptp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output cmd_type    head_cmd,
   output q_stat_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_cmd     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/ptp_back.sv @@
// ----------------------------------------------------------------------------
// Polynomial term parser back end
// Runs the term parser on queued commands and registers the results.
// ----------------------------------------------------------------------------
module ptp_back
   import ptp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     head_cmd,
   input  q_stat_type  q_stat,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   output bk_stat_type bk_stat
);

   localparam int CB = COEFF_BITS;
   localparam int EB = EXPO_BITS;
   localparam logic [CB+2:0] CMAX = {4'b0, {(CB-1){1'b1}}};
   localparam logic [EB+3:0] EMAX = {4'b0, {EB{1'b1}}};

   ps_type        state_ff, state_in;
   logic          neg_ff, neg_in;
   logic          cstart_ff, cstart_in;
   logic          cfrozen_ff, cfrozen_in;
   logic [CB-2:0] cacc_ff, cacc_in;
   logic [CB-1:0] held_ff, held_in;
   logic          estart_ff, estart_in;
   logic          efrozen_ff, efrozen_in;
   logic [EB-1:0] eacc_ff, eacc_in;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          pend_valid_ff, pend_valid_in;
   rsp_type       pend_ff, pend_in;

   logic          head_valid, out_free, fire, any_res;
   logic [CB+2:0] cext, cprod;
   logic [CB-2:0] csat;
   logic [EB+3:0] eext, eprod;
   logic [EB-1:0] esat;
   logic          char_v, mid_expo;
   rsp_type       char_r, end_r, first_r;

   function automatic logic [CB-1:0] sgn(input logic neg, input logic [CB-2:0] mag);
      logic [CB-1:0] ext;
      ext = {1'b0, mag};
      return neg ? (~ext + 1'b1) : ext;
   endfunction

   assign cext  = {4'b0, cacc_ff};
   assign cprod = (cext << 3) + (cext << 1) + {(CB-1)'(0), head_cmd.digit};
   assign csat  = (cprod > CMAX) ? {(CB-1){1'b1}} : cprod[CB-2:0];
   assign eext  = {4'b0, eacc_ff};
   assign eprod = (eext << 3) + (eext << 1) + {EB'(0), head_cmd.digit};
   assign esat  = (eprod > EMAX) ? {EB{1'b1}} : eprod[EB-1:0];

   assign head_valid = ~q_stat.empty;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign any_res    = char_v | head_cmd.last;
   assign fire       = head_valid & ~pend_valid_ff & (out_free | ~any_res);
   assign pop        = fire;

   always_comb begin
      state_in = state_ff;
      if (fire) begin
         case (state_ff)
            PS_COEFF: if (head_cmd.cls == CLS_X) state_in = PS_EXPO;
            PS_EXPO:  if (head_cmd.cls == CLS_SIGN) state_in = PS_COEFF;
            default:  state_in = PS_COEFF;
         endcase
         if (head_cmd.last) begin
            state_in = PS_COEFF;
         end
      end
   end

   always_comb begin
      neg_in     = neg_ff;
      cstart_in  = cstart_ff;
      cfrozen_in = cfrozen_ff;
      cacc_in    = cacc_ff;
      held_in    = held_ff;
      estart_in  = estart_ff;
      efrozen_in = efrozen_ff;
      eacc_in    = eacc_ff;
      char_v     = 1'b0;
      char_r     = '{KIND_INVALID, '0, '0, 1'b0};
      mid_expo   = (state_ff == PS_EXPO);
      case (state_ff)
         PS_COEFF: begin
            case (head_cmd.cls)
               CLS_SIGN: begin
                  neg_in = head_cmd.neg;
                  if (cstart_ff) cfrozen_in = 1'b1;
               end
               CLS_DIGIT: begin
                  if (!cfrozen_ff) begin
                     cstart_in = 1'b1;
                     cacc_in   = csat;
                  end
               end
               CLS_X: begin
                  held_in    = sgn(neg_ff, cstart_ff ? cacc_ff : (CB-1)'(1));
                  mid_expo   = 1'b1;
                  estart_in  = 1'b0;
                  efrozen_in = 1'b0;
                  eacc_in    = '0;
               end
               default: begin
                  if (cstart_ff) cfrozen_in = 1'b1;
                  char_v = 1'b1;
               end
            endcase
         end
         default: begin
            case (head_cmd.cls)
               CLS_SIGN: begin
                  char_v     = 1'b1;
                  char_r     = '{KIND_TERM, $signed(held_ff),
                                 estart_ff ? eacc_ff : EB'(1), 1'b0};
                  neg_in     = head_cmd.neg;
                  mid_expo   = 1'b0;
                  cstart_in  = 1'b0;
                  cfrozen_in = 1'b0;
                  cacc_in    = '0;
               end
               CLS_DIGIT: begin
                  if (!efrozen_ff) begin
                     estart_in = 1'b1;
                     eacc_in   = esat;
                  end
               end
               default: begin
                  if (estart_ff) efrozen_in = 1'b1;
                  char_v = 1'b1;
               end
            endcase
         end
      endcase

      if (mid_expo) begin
         end_r = '{KIND_TERM, $signed(held_in), estart_in ? eacc_in : EB'(1), 1'b1};
      end else if (cstart_in) begin
         end_r = '{KIND_TERM, $signed(sgn(neg_in, cacc_in)), '0, 1'b1};
      end else begin
         end_r = '{KIND_EMPTY, '0, '0, 1'b1};
      end
      first_r = char_v ? char_r : end_r;

      if (head_cmd.last) begin
         neg_in     = 1'b0;
         cstart_in  = 1'b0;
         cfrozen_in = 1'b0;
         cacc_in    = '0;
         held_in    = '0;
         estart_in  = 1'b0;
         efrozen_in = 1'b0;
         eacc_in    = '0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_ff;
         pend_valid_in = 1'b0;
      end else if (fire && any_res) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = first_r;
         pend_valid_in = char_v & head_cmd.last;
         pend_in       = end_r;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PS_COEFF;
         neg_ff        <= 1'b0;
         cstart_ff     <= 1'b0;
         cfrozen_ff    <= 1'b0;
         cacc_ff       <= '0;
         held_ff       <= '0;
         estart_ff     <= 1'b0;
         efrozen_ff    <= 1'b0;
         eacc_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (fire) begin
            neg_ff     <= neg_in;
            cstart_ff  <= cstart_in;
            cfrozen_ff <= cfrozen_in;
            cacc_ff    <= cacc_in;
            held_ff    <= held_in;
            estart_ff  <= estart_in;
            efrozen_ff <= efrozen_in;
            eacc_ff    <= eacc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign bk_stat.pend_valid = pend_valid_ff;
   assign bk_stat.busy       = head_valid;

endmodule
